>>> rtl/jdah_pkg.sv
// Shared constants, payload types and state encoding for the joint derived-allele histogram.
`timescale 1ns / 1ps

package jdah_pkg;

   // Sizing
   localparam int MAX_POP_SAMPLES = 32;
   localparam int COUNT_WIDTH     = 32;
   localparam int NUM_BINS        = (MAX_POP_SAMPLES + 1) * (MAX_POP_SAMPLES + 1);
   localparam int BIN_W           = $clog2(NUM_BINS);
   localparam int POP_W           = $clog2(MAX_POP_SAMPLES + 1);

   // Popcount tree: lanes are summed in groups, then the group sums are merged
   localparam int GROUP_SIZE = 8;
   localparam int NUM_GROUPS = (MAX_POP_SAMPLES + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GROUP_W    = $clog2(GROUP_SIZE + 1);

   // Fixed field widths
   localparam int KIND_W      = 1;
   localparam int BASE_W      = 2;
   localparam int BASES_W     = 64;
   localparam int INDEX_W     = 11;
   localparam int DERIVED_W   = 6;
   localparam int BIN_COUNT_W = 32;
   localparam int CFG_W       = 6;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_COLUMN = 1'b0;
   localparam logic [KIND_W-1:0] KIND_READ   = 1'b1;

   // Register select (word address bit)
   localparam logic REG_POP1_SIZE = 1'b0;
   localparam logic REG_POP2_SIZE = 1'b1;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BASE_W-1:0]  outgroup_base;
      logic [BASES_W-1:0] pop1_bases;
      logic [BASES_W-1:0] pop2_bases;
      logic [INDEX_W-1:0] bin_index;
   } req_payload_type;

   typedef struct packed {
      logic [DERIVED_W-1:0]   derived_pop1;
      logic [DERIVED_W-1:0]   derived_pop2;
      logic [BIN_COUNT_W-1:0] bin_count;
   } rsp_payload_type;

   typedef struct packed {
      logic [POP_W-1:0] pop1;
      logic [POP_W-1:0] pop2;
   } derived_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COUNT,
      ST_MERGE,
      ST_INDEX,
      ST_READ,
      ST_UPDATE
   } state_type;

endpackage

>>> rtl/joint_derived_allele_histogram_core.sv
// Top level of the joint derived-allele histogram: lanes, merge tree, bin RAM and control.
`timescale 1ns / 1ps

// Joint derived-allele histogram (joint site frequency spectrum).
// req channel (valid/ready): one item per transfer. A column item (kind 0) carries the
//   outgroup base and up to 32 sample bases per population; a read item (kind 1) names
//   one bin to return and clear. rsp channel (valid/ready): one result per item with the
//   two derived counts and the bin value (updated value for columns, old value for reads).
// csr port (APB-style, pready tied high): pop1_size at byte 0, pop2_size at byte 4,
//   decoded on paddr[2]; write only while the block is idle.
// Steps: each item passes in order through lane compare and group popcount, group
//   merge, bin index multiply, bin RAM read, then read-modify-write of the bin. Only one
//   item is in flight since each update depends on the bin RAM contents.
// Reset (synchronous, active high): the sizes return to 1 and a clearing pass writes zero
//   to all 1089 bins, one per cycle; req_ready stays low until the pass ends.
// Stall: a finished result sits in the output register; the next item is still taken,
//   and its update waits in the last step until the output register is free.
module joint_derived_allele_histogram_core (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  jdah_pkg::req_payload_type           req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output jdah_pkg::rsp_payload_type           rsp_data,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [jdah_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [jdah_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [jdah_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   import jdah_pkg::*;

   // ---------------------------------------------------------------- signals
   state_type             state_ff, state_in;
   logic [BIN_W-1:0]      clear_cnt_ff, clear_cnt_in;
   logic [CFG_W-1:0]      pop1_size_ff, pop1_size_in;
   logic [CFG_W-1:0]      pop2_size_ff, pop2_size_in;
   req_payload_type       req_ff;
   logic                  req_fire;
   logic                  csr_write;

   logic [POP_W-1:0]      eff1, eff2;
   logic [MAX_POP_SAMPLES-1:0] flags1, flags2;
   derived_type           derived;

   logic [POP_W:0]        span1;
   logic [2*POP_W:0]      bin_full;
   logic [BIN_W-1:0]      bin_ff, bin_in;
   logic                  in_range_ff, in_range_in;

   logic                  ram_we, ram_re;
   logic [BIN_W-1:0]      ram_waddr;
   logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;
   logic [COUNT_WIDTH-1:0] stored, bin_next;
   logic [63:0]           stored_wide, next_wide;

   logic                  update_go;
   logic                  rsp_load;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_ff, rsp_in;

   // ---------------------------------------------------------------- registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      pop1_size_in = pop1_size_ff;
      pop2_size_in = pop2_size_ff;
      if (csr_write) begin
         if (csr_paddr[2] == REG_POP1_SIZE) begin
            pop1_size_in = csr_pwdata[CFG_W-1:0];
         end else begin
            pop2_size_in = csr_pwdata[CFG_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_POP2_SIZE) ? CSR_DATA_W'(pop2_size_ff)
                                                       : CSR_DATA_W'(pop1_size_ff);

   // sizes above the lane count saturate
   assign eff1 = (pop1_size_ff > CFG_W'(MAX_POP_SAMPLES)) ? POP_W'(MAX_POP_SAMPLES)
                                                           : POP_W'(pop1_size_ff);
   assign eff2 = (pop2_size_ff > CFG_W'(MAX_POP_SAMPLES)) ? POP_W'(MAX_POP_SAMPLES)
                                                           : POP_W'(pop2_size_ff);

   // ---------------------------------------------------------------- lanes
   for (genvar i = 0; i < MAX_POP_SAMPLES; i++) begin : g_lane
      jdah_lane u_lane1 (
         .sample_base   (req_ff.pop1_bases[2*i +: 2]),
         .outgroup_base (req_ff.outgroup_base),
         .lane_enable   (eff1 > POP_W'(i)),
         .derived_flag  (flags1[i])
      );
      jdah_lane u_lane2 (
         .sample_base   (req_ff.pop2_bases[2*i +: 2]),
         .outgroup_base (req_ff.outgroup_base),
         .lane_enable   (eff2 > POP_W'(i)),
         .derived_flag  (flags2[i])
      );
   end

   // counts are valid from ST_INDEX on and hold while req_ff holds
   jdah_merge u_merge (
      .clock   (clock),
      .flags1  (flags1),
      .flags2  (flags2),
      .derived (derived)
   );

   // ---------------------------------------------------------------- bin index
   // bin = pop2_count * (pop1_size + 1) + pop1_count
   always_comb begin
      span1    = {1'b0, eff1} + (POP_W+1)'(1);
      bin_full = (2*POP_W+1)'(derived.pop2) * (2*POP_W+1)'(span1)
               + (2*POP_W+1)'(derived.pop1);
      if (req_ff.kind == KIND_READ) begin
         bin_in      = BIN_W'(req_ff.bin_index);
         in_range_in = int'(req_ff.bin_index) < NUM_BINS;
      end else begin
         bin_in      = BIN_W'(bin_full);
         in_range_in = int'(bin_full) < NUM_BINS;
      end
   end

   // ---------------------------------------------------------------- bin RAM
   jdah_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (NUM_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (bin_ff),
      .rd_data (ram_rdata)
   );

   // read data holds while the last step waits, since no new read is issued
   assign stored      = in_range_ff ? ram_rdata : '0;
   assign bin_next    = (stored == '1) ? stored : stored + COUNT_WIDTH'(1);
   assign stored_wide = 64'(stored);
   assign next_wide   = 64'(bin_next);

   always_comb begin
      rsp_in = '0;
      if (req_ff.kind == KIND_READ) begin
         rsp_in.bin_count = stored_wide[BIN_COUNT_W-1:0];
      end else begin
         rsp_in.derived_pop1 = DERIVED_W'(derived.pop1);
         rsp_in.derived_pop2 = DERIVED_W'(derived.pop2);
         rsp_in.bin_count    = in_range_ff ? next_wide[BIN_COUNT_W-1:0] : '0;
      end
   end

   // ---------------------------------------------------------------- control
   assign update_go = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid & req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_cnt_ff == BIN_W'(NUM_BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT:  state_in = ST_MERGE;
         ST_MERGE:  state_in = ST_INDEX;
         ST_INDEX:  state_in = ST_READ;
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (update_go) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      ram_re       = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = bin_ff;
      ram_wdata    = '0;
      rsp_load     = 1'b0;
      clear_cnt_in = clear_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_we       = 1'b1;
            ram_waddr    = clear_cnt_ff;
            clear_cnt_in = clear_cnt_ff + BIN_W'(1);
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_READ: begin
            ram_re = in_range_ff;
         end
         ST_UPDATE: begin
            if (update_go) begin
               rsp_load  = 1'b1;
               ram_we    = in_range_ff;
               ram_wdata = (req_ff.kind == KIND_READ) ? '0 : bin_next;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         pop1_size_ff <= CFG_W'(1);
         pop2_size_ff <= CFG_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         pop1_size_ff <= pop1_size_in;
         pop2_size_ff <= pop2_size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_INDEX) begin
         bin_ff      <= bin_in;
         in_range_ff <= in_range_in;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- checks
   // only one item in flight
   assert property (@(posedge clock) disable iff (reset) req_fire |=> !req_ready)
      else $error("second item accepted while one is in flight");

   // bin RAM written only by the clearing pass or the update step
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_UPDATE))
      else $error("bin RAM written outside clear or update");

   // column counts never exceed the population sizes
   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && req_ff.kind == KIND_COLUMN) |->
         (derived.pop1 <= eff1 && derived.pop2 <= eff2 && in_range_ff))
      else $error("derived count out of range for column");

   // a read beyond the last bin returns zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && req_ff.kind == KIND_READ && !in_range_ff) |-> (rsp_in.bin_count == '0))
      else $error("out-of-range read returned nonzero");

endmodule

>>> rtl/jdah_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module jdah_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/jdah_lane.sv
// One sample lane: flags a sample whose base differs from the outgroup.
`timescale 1ns / 1ps

module jdah_lane (
   input  logic [1:0] sample_base,
   input  logic [1:0] outgroup_base,
   input  logic       lane_enable,
   output logic       derived_flag
);

   // Lanes beyond the population size never count
   assign derived_flag = lane_enable & (sample_base != outgroup_base);

endmodule

>>> rtl/jdah_merge.sv
// Two-stage registered popcount tree that merges the lane flags of both populations.
`timescale 1ns / 1ps

module jdah_merge (
   input  logic                                clock,
   input  logic [jdah_pkg::MAX_POP_SAMPLES-1:0] flags1,
   input  logic [jdah_pkg::MAX_POP_SAMPLES-1:0] flags2,
   output jdah_pkg::derived_type                derived
);

   import jdah_pkg::*;

   localparam int PAD_W = NUM_GROUPS * GROUP_SIZE;

   logic [PAD_W-1:0]   pad1;
   logic [PAD_W-1:0]   pad2;
   logic [GROUP_W-1:0] grp1_ff [NUM_GROUPS];
   logic [GROUP_W-1:0] grp1_in [NUM_GROUPS];
   logic [GROUP_W-1:0] grp2_ff [NUM_GROUPS];
   logic [GROUP_W-1:0] grp2_in [NUM_GROUPS];
   derived_type        total_ff;
   derived_type        total_in;

   assign pad1 = PAD_W'(flags1);
   assign pad2 = PAD_W'(flags2);

   // Stage 1: per-group sums
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp1_in[g] = '0;
         grp2_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            grp1_in[g] = grp1_in[g] + GROUP_W'(pad1[g*GROUP_SIZE+k]);
            grp2_in[g] = grp2_in[g] + GROUP_W'(pad2[g*GROUP_SIZE+k]);
         end
      end
   end

   // Stage 2: group sums into totals
   always_comb begin
      total_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         total_in.pop1 = total_in.pop1 + POP_W'(grp1_ff[g]);
         total_in.pop2 = total_in.pop2 + POP_W'(grp2_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      grp1_ff  <= grp1_in;
      grp2_ff  <= grp2_in;
      total_ff <= total_in;
   end

   assign derived = total_ff;

endmodule

>>> tb/sv/joint_derived_allele_histogram_core_test.sv
// Self-checking testbench for the joint derived-allele histogram core.
`timescale 1ns / 1ps

module joint_derived_allele_histogram_core_test;
   import jdah_pkg::*;

   // Register byte addresses: pop1_size at 0, pop2_size at 4
   localparam logic [CSR_ADDR_W-1:0] ADDR_POP1_SIZE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_POP2_SIZE = 3'd4;

   // Watchdog: quiet cycles allowed with no transfer on either channel.
   // Covers the clearing pass and the long output hold-off many times over.
   localparam int QUIET_LIMIT     = 20000;
   localparam int HOLD_OFF_CYCLES = 400;
   // Cycles left after the last result before registers change or the run ends
   localparam int SETTLE_CYCLES   = 12;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   joint_derived_allele_histogram_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Spectrum predictor: own copy of the bins and the two size registers
   // ---------------------------------------------------------------------------
   logic [COUNT_WIDTH-1:0] bin_store [NUM_BINS];
   logic [CFG_W-1:0]       size_pop1;
   logic [CFG_W-1:0]       size_pop2;

   // Results still owed by the block, oldest first
   rsp_payload_type spectrum_results [$];

   int mismatch_count = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;

   // Hold-off requests from the test flow; the receiver process counts them out
   int hold_off_requests = 0;
   int hold_off_taken = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   // Sizes above the lane count saturate
   function automatic int effective_size(input logic [CFG_W-1:0] size);
      return (int'(size) > MAX_POP_SAMPLES) ? MAX_POP_SAMPLES : int'(size);
   endfunction

   // Lanes at or beyond the population size are ignored
   function automatic int count_derived(input logic [BASES_W-1:0] lanes,
                                        input logic [BASE_W-1:0] outg, input int size);
      int n;
      n = 0;
      for (int i = 0; i < size; i++)
         if (lanes[2*i +: 2] != outg) n++;
      return n;
   endfunction

   function automatic rsp_payload_type histogram_step(input req_payload_type item);
      rsp_payload_type res;
      int s1, s2, d1, d2, bin;
      res = '0;
      if (item.kind == KIND_READ) begin
         // read and clear; indexes past the last bin return zero and touch nothing
         if (int'(item.bin_index) < NUM_BINS) begin
            res.bin_count = BIN_COUNT_W'(bin_store[item.bin_index]);
            bin_store[item.bin_index] = '0;
         end
      end else begin
         s1 = effective_size(size_pop1);
         s2 = effective_size(size_pop2);
         d1 = count_derived(item.pop1_bases, item.outgroup_base, s1);
         d2 = count_derived(item.pop2_bases, item.outgroup_base, s2);
         bin = d2 * (s1 + 1) + d1;
         if (bin < NUM_BINS) begin
            if (bin_store[bin] != '1) bin_store[bin] = bin_store[bin] + COUNT_WIDTH'(1);
            res.bin_count = BIN_COUNT_W'(bin_store[bin]);
         end
         res.derived_pop1 = DERIVED_W'(d1);
         res.derived_pop2 = DERIVED_W'(d2);
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Item builders
   // ---------------------------------------------------------------------------
   function automatic req_payload_type column_item(input logic [BASE_W-1:0] outg,
                                                   input logic [BASES_W-1:0] p1,
                                                   input logic [BASES_W-1:0] p2);
      req_payload_type item;
      item.kind          = KIND_COLUMN;
      item.outgroup_base = outg;
      item.pop1_bases    = p1;
      item.pop2_bases    = p2;
      item.bin_index     = INDEX_W'($urandom);
      return item;
   endfunction

   function automatic req_payload_type read_item(input logic [INDEX_W-1:0] idx);
      req_payload_type item;
      item.kind          = KIND_READ;
      item.outgroup_base = BASE_W'($urandom);
      item.pop1_bases    = {$urandom, $urandom};
      item.pop2_bases    = {$urandom, $urandom};
      item.bin_index     = idx;
      return item;
   endfunction

   // Each lane differs from the outgroup with probability pct percent
   function automatic logic [BASES_W-1:0] lanes_with_derived(input logic [BASE_W-1:0] outg,
                                                             input int pct);
      logic [BASES_W-1:0] lanes;
      lanes = '0;
      for (int i = 0; i < MAX_POP_SAMPLES; i++) begin
         if ($urandom_range(0, 99) < pct) lanes[2*i +: 2] = outg ^ BASE_W'($urandom_range(1, 3));
         else lanes[2*i +: 2] = outg;
      end
      return lanes;
   endfunction

   function automatic req_payload_type random_column();
      logic [BASE_W-1:0] outg;
      outg = BASE_W'($urandom_range(0, 3));
      // mostly spread derived counts across the whole range; some pure noise
      if ($urandom_range(0, 9) == 0)
         return column_item(outg, {$urandom, $urandom}, {$urandom, $urandom});
      return column_item(outg, lanes_with_derived(outg, $urandom_range(0, 100)),
                         lanes_with_derived(outg, $urandom_range(0, 100)));
   endfunction

   function automatic req_payload_type random_read();
      int s1, s2, pick;
      s1 = effective_size(size_pop1);
      s2 = effective_size(size_pop2);
      pick = $urandom_range(0, 9);
      // aim at bins the current sizes can reach, else anywhere, else out of range
      if (pick < 7)
         return read_item(INDEX_W'($urandom_range(0, s2) * (s1 + 1) + $urandom_range(0, s1)));
      if (pick < 9)
         return read_item(INDEX_W'($urandom_range(0, NUM_BINS - 1)));
      return read_item(INDEX_W'($urandom_range(NUM_BINS, 2047)));
   endfunction

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Every result transfer is compared against the oldest prediction
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (spectrum_results.size() == 0) begin
            report_mismatch("unexpected result, bin_count", 64'(rsp_data.bin_count), '0);
         end else begin
            want = spectrum_results.pop_front();
            if (rsp_data.derived_pop1 !== want.derived_pop1)
               report_mismatch("derived_pop1", 64'(rsp_data.derived_pop1),
                               64'(want.derived_pop1));
            if (rsp_data.derived_pop2 !== want.derived_pop2)
               report_mismatch("derived_pop2", 64'(rsp_data.derived_pop2),
                               64'(want.derived_pop2));
            if (rsp_data.bin_count !== want.bin_count)
               report_mismatch("bin_count", 64'(rsp_data.bin_count), 64'(want.bin_count));
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off counted here when one is requested
   always @(posedge clock) begin
      if (hold_off_requests != hold_off_taken) begin
         hold_off_taken <= hold_off_requests;
         hold_left      <= HOLD_OFF_CYCLES;
         rsp_ready      <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Watchdog: too long with no transfer on either channel ends the run
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("joint_derived_allele_histogram_core_test: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Drivers. Every task is entered and left just after a rising edge.
   // ---------------------------------------------------------------------------
   task automatic send_item(input req_payload_type item);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // transfer happened at this edge
      spectrum_results.push_back(histogram_step(item));
   endtask

   // Drop valid, then wait until every predicted result has been seen
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (spectrum_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == ADDR_POP1_SIZE) size_pop1 = data[CFG_W-1:0];
      else size_pop2 = data[CFG_W-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check(input logic [CSR_ADDR_W-1:0] addr, input logic [CFG_W-1:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(want))
         report_mismatch(addr == ADDR_POP1_SIZE ? "pop1_size readback" : "pop2_size readback",
                         64'(csr_prdata), 64'(want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Sizes change only with the block idle; upper data bits are junk and must be dropped
   task automatic set_sizes(input int p1, input int p2);
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(ADDR_POP1_SIZE, CSR_DATA_W'({$urandom, 6'(p1)}));
      csr_write(ADDR_POP2_SIZE, CSR_DATA_W'({$urandom, 6'(p2)}));
      csr_check(ADDR_POP1_SIZE, CFG_W'(p1));
      csr_check(ADDR_POP2_SIZE, CFG_W'(p2));
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset values, then both registers at saturating, zero and default sizes
   task automatic test_register_access();
      csr_check(ADDR_POP1_SIZE, 6'd1);
      csr_check(ADDR_POP2_SIZE, 6'd1);
      set_sizes(33, 63);
      set_sizes(0, 0);
      set_sizes(1, 1);
   endtask

   task automatic test_directed_columns();
      // default sizes: all match, then both lanes derived (bin 3), read it twice
      send_item(column_item(2'd0, '0, '0));
      send_item(column_item(2'd3, '0, '0));
      send_item(read_item(11'd3));
      send_item(read_item(11'd3));
      // reads past the last bin return zero, then the last bin itself is read
      send_item(read_item(11'd1089));
      send_item(read_item(11'd2047));
      send_item(read_item(11'd1088));
      // full populations: last bin, first bin, single-population extremes
      set_sizes(32, 32);
      send_item(column_item(2'd2, '1, '1));
      send_item(column_item(2'd1, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555));
      send_item(column_item(2'd0, '1, '0));
      send_item(column_item(2'd3, '0, '1));
      send_item(read_item(11'd1088));
      send_item(read_item(11'd32));
      // empty populations count nothing
      set_sizes(0, 0);
      send_item(column_item(2'd1, '1, '1));
      send_item(read_item(11'd0));
      // lanes past the population size must not count
      set_sizes(5, 9);
      send_item(column_item(2'd0, 64'hFFFF_FFFF_FFFF_FC00, 64'hFFFF_FFFF_FFFC_0000));
      send_item(column_item(2'd0, 64'h0000_0000_0000_03FF, 64'h0000_0000_0003_FFFF));
      send_item(read_item(11'd59));
      // a size change leaves earlier counts in place
      set_sizes(1, 1);
      send_item(read_item(11'd0));
      send_item(read_item(11'd3));
   endtask

   task automatic test_random_traffic(input int p1, input int p2, input int n_items);
      set_sizes(p1, p2);
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 3) == 0) send_item(random_read());
         else send_item(random_column());
      end
   endtask

   // Receiver holds off long enough that the block backs up into req_ready
   task automatic test_output_stall();
      int saved_pct;
      saved_pct = sender_idle_pct;
      sender_idle_pct = 0;
      hold_off_requests = hold_off_requests + 1;
      for (int i = 0; i < 20; i++) send_item(random_column());
      sender_idle_pct = saved_pct;
   endtask

   // Sender goes quiet until the block has handed back everything
   task automatic test_sender_pause();
      for (int i = 0; i < 10; i++) send_item(random_column());
      wait_drain();
      for (int i = 0; i < 10; i++) send_item(random_read());
   endtask

   initial begin
      for (int i = 0; i < NUM_BINS; i++) bin_store[i] = '0;
      size_pop1 = 6'd1;
      size_pop2 = 6'd1;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles a third of the time, receiver more than half
      set_idling(33, 58);
      test_register_access();
      test_directed_columns();
      test_random_traffic(32, 32, 200);
      test_random_traffic(0, 17, 150);
      test_random_traffic(63, 2, 200);
      test_output_stall();

      // roles swapped
      set_idling(58, 33);
      test_random_traffic(33, 0, 200);
      test_random_traffic(5, 31, 200);
      test_random_traffic($urandom_range(0, 63), $urandom_range(0, 63), 200);

      // back to back
      set_idling(0, 0);
      test_random_traffic(1, 1, 250);
      test_random_traffic(32, 32, 200);
      test_random_traffic($urandom_range(0, 63), $urandom_range(0, 63), 200);
      test_sender_pause();

      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("joint_derived_allele_histogram_core_test: done, clean");
      end else begin
         $display("joint_derived_allele_histogram_core_test: done, errors");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/jdah_pkg.sv
rtl/jdah_ram.sv
rtl/jdah_lane.sv
rtl/jdah_merge.sv
rtl/joint_derived_allele_histogram_core.sv
tb/sv/joint_derived_allele_histogram_core_test.sv
